// ----- rtl/ubds_pkg.sv -----
package ubds_pkg;

    localparam int DATA_W = 32;
    localparam int BAUD_W = 23;
    localparam int DIV_W  = 8;
    localparam int STAT_W = 2;
    localparam int PCT_W  = 7;
    localparam int IDX_W  = 2;

    localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_RATE_HIGH = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_ERR_HIGH  = 2'd2;

    localparam logic [IDX_W-1:0] REG_CLOCK_HZ    = 2'd0;
    localparam logic [IDX_W-1:0] REG_CLOCK_DIV8  = 2'd1;
    localparam logic [IDX_W-1:0] REG_MAX_ERR_PCT = 2'd2;

    localparam logic [DATA_W-1:0] CLOCK_HZ_RST = 32'd100000000;
    localparam logic [PCT_W-1:0]  MAX_PCT_RST  = 7'd3;
    localparam logic [PCT_W-1:0]  PCT_SCALE    = 7'd100;
    localparam logic [DATA_W-1:0] ERR_NONE     = 32'hFFFF_FFFF;

    typedef enum logic [3:0] {
        S_IDLE,
        S_NEXT_DIV,
        S_DIV1_START,
        S_DIV1_WAIT,
        S_CNT_CHECK,
        S_DIV2_START,
        S_DIV2_WAIT,
        S_PCT_MUL,
        S_PCT_CMP
    } state_t;

    typedef struct packed {
        logic              go;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ----- rtl/ubds_div.sv -----
module ubds_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  ubds_pkg::div_req_t req,
    output ubds_pkg::div_rsp_t rsp
);
    import ubds_pkg::*;

    localparam int CNT_W = $clog2(DATA_W + 1);
    localparam logic [CNT_W-1:0] STEPS = CNT_W'(DATA_W);
    localparam logic [CNT_W-1:0] LAST  = CNT_W'(1);

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] dsr_reg, dsr_next;
    logic [DATA_W:0]   rem_shift;
    logic [DATA_W:0]   diff;
    logic              fits;

    // restoring divide, one quotient bit per cycle
    assign rem_shift = {rem_reg, quo_reg[DATA_W-1]};
    assign diff      = rem_shift - {1'b0, dsr_reg};
    assign fits      = ~diff[DATA_W];

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (req.go)
        begin
            cnt_next = STEPS;
            rem_next = '0;
            quo_next = req.dividend;
            dsr_next = req.divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - LAST;
            done_next = (cnt_reg == LAST);
            rem_next  = fits ? diff[DATA_W-1:0] : rem_shift[DATA_W-1:0];
            quo_next  = {quo_reg[DATA_W-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

`ifndef NO_ASSERTIONS
    a_go_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.go |-> cnt_reg == '0)
        else $error("divide started while running");

    a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> cnt_reg == '0 && $past(cnt_reg) == LAST)
        else $error("divide done out of sequence");
`endif

endmodule

// ----- rtl/uart_baud_divisor_search_unit.sv -----
// channel  | transfer on                 | payload
// ---------+-----------------------------+----------------------------------------------
// command  | start & !busy at clk rise   | requested_baud
// result   | done high for one cycle     | status, generator_count, divider, rate_error
// config   | wr_en at clk rise           | wr_index, wr_data
//
// A rate above half clock is answered in the cycle after the command.
// Otherwise each divider value takes up to two passes of the 32-step serial
// divider plus sequencer steps, over the default range of 251 values.
// Busy stays high for the whole search.
// Asynchronous active-low reset sets the state, done and config registers to their defaults.
// The receiver cannot stall: the result outputs hold until the next result is written.
module uart_baud_divisor_search_unit
#(
    parameter int DIV_LOW = 4,
    parameter int DIV_END = 255
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [ubds_pkg::BAUD_W-1:0]   requested_baud,
    input  logic                          wr_en,
    input  logic [ubds_pkg::IDX_W-1:0]    wr_index,
    input  logic [ubds_pkg::DATA_W-1:0]   wr_data,
    output logic                          done,
    output logic [ubds_pkg::STAT_W-1:0]   status,
    output logic [ubds_pkg::DATA_W-1:0]   generator_count,
    output logic [ubds_pkg::DIV_W-1:0]    divider,
    output logic [ubds_pkg::DATA_W-1:0]   rate_error
);
    import ubds_pkg::*;

    localparam logic [DIV_W-1:0] DIV_FIRST   = DIV_W'(DIV_LOW);
    localparam logic [DIV_W-1:0] DIV_STOP    = DIV_W'(DIV_END);
    localparam bit               RANGE_EMPTY = (DIV_LOW >= DIV_END);
    localparam int               DEN_W       = BAUD_W + DIV_W;
    localparam int               LHS_W       = DATA_W + PCT_W;
    localparam int               RHS_W       = BAUD_W + PCT_W + 1;

    state_t state_reg, state_next;

    logic [DATA_W-1:0] clock_hz_reg;
    logic              clock_div8_reg;
    logic [PCT_W-1:0]  max_pct_reg;

    logic [BAUD_W-1:0] baud_reg;
    logic [DIV_W-1:0]  d_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DATA_W-1:0] count_reg;
    logic [DATA_W-1:0] prod_reg;
    logic              found_reg;
    logic [DATA_W-1:0] best_err_reg;
    logic [DATA_W-1:0] best_count_reg;
    logic [DIV_W-1:0]  best_div_reg;
    logic [LHS_W-1:0]  lhs_reg;
    logic [RHS_W-1:0]  rhs_reg;

    logic              done_reg;
    logic [STAT_W-1:0] status_reg;
    logic [DATA_W-1:0] gen_count_reg;
    logic [DIV_W-1:0]  divider_reg;
    logic [DATA_W-1:0] rate_err_reg;

    logic [DATA_W-1:0] work_clk;
    logic              rate_high;
    logic [DIV_W-1:0]  d_plus1;
    logic [DATA_W-1:0] achieved;
    logic [DATA_W-1:0] err;
    logic              better;

    // sequencer controls
    logic              accept;
    logic              den_load;
    logic              div1_go;
    logic              div2_go;
    logic              cnt_load;
    logic              prod_load;
    logic              cand_done;
    logic              d_inc;
    logic              pct_load;
    logic              finish;
    logic [STAT_W-1:0] fin_status;
    logic [DATA_W-1:0] fin_count;
    logic [DIV_W-1:0]  fin_div;
    logic [DATA_W-1:0] fin_err;

    div_req_t div_req;
    div_rsp_t div_rsp;

    ubds_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign work_clk  = clock_div8_reg ? (clock_hz_reg >> 3) : clock_hz_reg;
    assign rate_high = {{(DATA_W-BAUD_W-1){1'b0}}, requested_baud, 1'b0} > clock_hz_reg;
    assign d_plus1   = d_reg + DIV_W'(1);
    assign achieved  = div_rsp.quotient;
    assign err       = (achieved > {{(DATA_W-BAUD_W){1'b0}}, baud_reg})
                     ? achieved - {{(DATA_W-BAUD_W){1'b0}}, baud_reg}
                     : {{(DATA_W-BAUD_W){1'b0}}, baud_reg} - achieved;
    assign better    = !found_reg || (err < best_err_reg);

    assign div_req.go       = div1_go | div2_go;
    assign div_req.dividend = work_clk;
    assign div_req.divisor  = div2_go ? prod_reg : {{(DATA_W-DEN_W){1'b0}}, den_reg};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (rate_high)
                        state_next = S_IDLE;
                    else if (RANGE_EMPTY)
                        state_next = S_PCT_CMP;
                    else
                        state_next = S_NEXT_DIV;
                end
            end
            S_NEXT_DIV:
                state_next = (d_reg == DIV_STOP) ? S_PCT_MUL : S_DIV1_START;
            S_DIV1_START:
                state_next = (den_reg == '0) ? S_NEXT_DIV : S_DIV1_WAIT;
            S_DIV1_WAIT:
                if (div_rsp.done)
                    state_next = S_CNT_CHECK;
            S_CNT_CHECK:
                state_next = (count_reg == '0) ? S_NEXT_DIV : S_DIV2_START;
            S_DIV2_START:
                state_next = S_DIV2_WAIT;
            S_DIV2_WAIT:
                if (div_rsp.done)
                    state_next = S_NEXT_DIV;
            S_PCT_MUL:
                state_next = S_PCT_CMP;
            S_PCT_CMP:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        accept     = 1'b0;
        den_load   = 1'b0;
        div1_go    = 1'b0;
        div2_go    = 1'b0;
        cnt_load   = 1'b0;
        prod_load  = 1'b0;
        cand_done  = 1'b0;
        d_inc      = 1'b0;
        pct_load   = 1'b0;
        finish     = 1'b0;
        fin_status = STATUS_OK;
        fin_count  = '0;
        fin_div    = '0;
        fin_err    = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    accept = 1'b1;
                    if (rate_high)
                    begin
                        finish     = 1'b1;
                        fin_status = STATUS_RATE_HIGH;
                    end
                end
            end
            S_NEXT_DIV:
                den_load = (d_reg != DIV_STOP);
            S_DIV1_START:
            begin
                if (den_reg == '0)
                    d_inc = 1'b1;
                else
                    div1_go = 1'b1;
            end
            S_DIV1_WAIT:
                cnt_load = div_rsp.done;
            S_CNT_CHECK:
            begin
                if (count_reg == '0)
                    d_inc = 1'b1;
                else
                    prod_load = 1'b1;
            end
            S_DIV2_START:
                div2_go = 1'b1;
            S_DIV2_WAIT:
            begin
                cand_done = div_rsp.done;
                d_inc     = div_rsp.done;
            end
            S_PCT_MUL:
                pct_load = 1'b1;
            S_PCT_CMP:
            begin
                finish = 1'b1;
                if (!found_reg)
                begin
                    fin_status = STATUS_ERR_HIGH;
                    fin_err    = ERR_NONE;
                end
                else if (lhs_reg >= {{(LHS_W-RHS_W){1'b0}}, rhs_reg})
                begin
                    fin_status = STATUS_ERR_HIGH;
                    fin_err    = best_err_reg;
                end
                else
                begin
                    fin_count = best_count_reg;
                    fin_div   = best_div_reg;
                    fin_err   = best_err_reg;
                end
            end
            default:
            begin
                finish = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            clock_hz_reg   <= CLOCK_HZ_RST;
            clock_div8_reg <= 1'b0;
            max_pct_reg    <= MAX_PCT_RST;
            found_reg      <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= finish;
            if (wr_en)
            begin
                case (wr_index)
                    REG_CLOCK_HZ:    clock_hz_reg   <= wr_data;
                    REG_CLOCK_DIV8:  clock_div8_reg <= wr_data[0];
                    REG_MAX_ERR_PCT: max_pct_reg    <= wr_data[PCT_W-1:0];
                    default:         clock_div8_reg <= clock_div8_reg;
                endcase
            end
            if (accept)
                found_reg <= 1'b0;
            else if (cand_done && better)
                found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            baud_reg <= requested_baud;
            d_reg    <= DIV_FIRST;
        end
        else if (d_inc)
            d_reg <= d_plus1;
        if (den_load)
            den_reg <= DEN_W'(baud_reg) * DEN_W'(d_plus1);
        if (cnt_load)
            count_reg <= div_rsp.quotient;
        if (prod_load)
            prod_reg <= DATA_W'(count_reg * d_plus1);
        if (cand_done && better)
        begin
            best_err_reg   <= err;
            best_count_reg <= count_reg;
            best_div_reg   <= d_reg;
        end
        // floor(err*100/baud) > max  <=>  err*100 >= (max+1)*baud
        if (pct_load)
        begin
            lhs_reg <= LHS_W'(best_err_reg) * LHS_W'(PCT_SCALE);
            rhs_reg <= RHS_W'({1'b0, max_pct_reg} + (PCT_W+1)'(1)) * RHS_W'(baud_reg);
        end
        if (finish)
        begin
            status_reg    <= fin_status;
            gen_count_reg <= fin_count;
            divider_reg   <= fin_div;
            rate_err_reg  <= fin_err;
        end
    end

    assign busy            = (state_reg != S_IDLE);
    assign done            = done_reg;
    assign status          = status_reg;
    assign generator_count = gen_count_reg;
    assign divider         = divider_reg;
    assign rate_error      = rate_err_reg;

`ifndef NO_ASSERTIONS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == S_IDLE)
        else $error("result strobe while searching");

    a_ok_range: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && status_reg == STATUS_OK |->
            divider_reg >= DIV_FIRST && divider_reg < DIV_STOP && gen_count_reg != '0)
        else $error("accepted result outside divider range");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && status_reg != STATUS_OK |-> gen_count_reg == '0 && divider_reg == '0)
        else $error("rejected result carries a setting");

    a_wait_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.go |=> state_reg == S_DIV1_WAIT || state_reg == S_DIV2_WAIT)
        else $error("divide issued outside a wait sequence");
`endif

endmodule
